// ===== design/lru_pkg.sv =====
// Package for the LRU key-value cache: sizes, widths and operation codes.
`timescale 1ns / 1ps

package lru_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int AGE_W   = (IDX_W < 1) ? 1 : IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_SET = 1'b1
    } func_t;

    typedef logic [ENTRIES-1:0] entry_vec_t;
    typedef logic [AGE_W-1:0]   age_t;
    typedef logic [OCC_W-1:0]   occ_t;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps

// Fully associative 16-entry key-value cache with least-recently-used
// replacement. Each input beat is a get (s_tuser = 0) or a set (s_tuser = 1)
// on a 32-bit key. A get returns the stored value and a hit flag, or -1 with
// no hit; a set updates a present key or inserts a new one, evicting the least
// recent entry once occupancy reaches the capacity register (0 acts as 1,
// above 16 acts as 16; lowering it keeps present entries). Every input beat
// gives exactly one result beat, in the cycle after it is accepted. The lookup,
// age update and insertion for a beat all settle in the cycle it is accepted,
// against the 16 parallel key comparators, so a beat can be taken every cycle;
// the result register stalls intake only while a result waits and m_tready is
// low. Write the capacity only while no beat is in flight.
module lru_key_value_cache (
    input  logic                      aclk,
    input  logic                      aresetn,
    // capacity register write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lru_pkg::CAP_W-1:0] cfg_data,
    // requests
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,   // key[31:0], value[63:32]
    input  logic                      s_tuser,   // func
    // results
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // read_value[31:0]
    output logic [1:0]                m_tuser    // hit[0], evicted[1]
);
    import lru_pkg::*;

    logic [CAP_W-1:0]  capacity_reg;
    entry_vec_t        valid_reg, valid_next;
    logic [KEY_W-1:0]  key_reg  [ENTRIES];
    logic [DATA_W-1:0] data_reg [ENTRIES];
    age_t              age_reg  [ENTRIES];
    age_t              age_next [ENTRIES];
    occ_t              occ_reg, occ_next;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    logic              hit_reg, hit_next;
    logic              evict_reg, evict_next;

    logic [KEY_W-1:0]  in_key;
    logic [DATA_W-1:0] in_value;
    func_t             in_func;
    logic              accept;

    entry_vec_t        match;
    logic              hit;
    logic [DATA_W-1:0] hit_data;
    age_t              hit_age;
    occ_t              eff_cap;
    logic              do_evict;
    entry_vec_t        victim;
    entry_vec_t        valid_kept;
    entry_vec_t        free_slot;
    logic              found_free;
    logic              wr_data;
    entry_vec_t        wr_sel;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_value = s_tdata[KEY_W +: DATA_W];
    assign in_func  = func_t'(s_tuser);

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = {evict_reg, hit_reg};

    // capacity clamp: 0 acts as 1, above ENTRIES acts as ENTRIES
    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = occ_t'(1);
        end else if (OCC_W'(capacity_reg) > occ_t'(ENTRIES)) begin
            eff_cap = occ_t'(ENTRIES);
        end else begin
            eff_cap = OCC_W'(capacity_reg);
        end
    end

    // parallel lookup; at most one entry matches
    always_comb begin
        hit_data = '0;
        hit_age  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == in_key);
            if (match[i]) begin
                hit_data = hit_data | data_reg[i];
                hit_age  = hit_age | age_reg[i];
            end
        end
        hit = |match;
    end

    // ages of valid entries are 0 .. occ-1, so the oldest has age occ-1
    always_comb begin
        do_evict = (in_func == FUNC_SET) && !hit && (occ_reg >= eff_cap);
        for (int i = 0; i < ENTRIES; i++) begin
            victim[i] = do_evict && valid_reg[i]
                        && (AGE_W'(occ_reg - occ_t'(1)) == age_reg[i]);
        end
        valid_kept = valid_reg & ~victim;
    end

    // lowest free slot after eviction
    always_comb begin
        free_slot  = '0;
        found_free = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!valid_kept[i] && !found_free) begin
                free_slot[i] = 1'b1;
                found_free   = 1'b1;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        wr_data    = 1'b0;
        wr_sel     = '0;
        rdata_next = '0;
        hit_next   = hit;
        evict_next = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            age_next[i] = age_reg[i];
        end
        if (in_func == FUNC_GET) begin
            rdata_next = hit ? hit_data : MISS_VALUE;
        end
        if (hit) begin
            // touch: younger entries age by one, the hit entry becomes newest
            for (int i = 0; i < ENTRIES; i++) begin
                if (match[i]) begin
                    age_next[i] = '0;
                end else if (valid_reg[i] && age_reg[i] < hit_age) begin
                    age_next[i] = age_reg[i] + age_t'(1);
                end
            end
            if (in_func == FUNC_SET) begin
                wr_data = 1'b1;
                wr_sel  = match;
            end
        end else if (in_func == FUNC_SET) begin
            evict_next = do_evict;
            for (int i = 0; i < ENTRIES; i++) begin
                if (free_slot[i]) begin
                    age_next[i] = '0;
                end else if (valid_kept[i]) begin
                    age_next[i] = age_reg[i] + age_t'(1);
                end
            end
            if (found_free) begin
                valid_next = valid_kept | free_slot;
                wr_data    = 1'b1;
                wr_sel     = free_slot;
                if (!do_evict) begin
                    occ_next = occ_reg + occ_t'(1);
                end
            end else begin
                valid_next = valid_kept;
                if (do_evict) begin
                    occ_next = occ_reg - occ_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            valid_reg    <= '0;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (accept) begin
                valid_reg    <= valid_next;
                occ_reg      <= occ_next;
                m_tvalid_reg <= 1'b1;
                for (int i = 0; i < ENTRIES; i++) begin
                    age_reg[i] <= age_next[i];
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: entry store and result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= rdata_next;
            hit_reg   <= hit_next;
            evict_reg <= evict_next;
            if (wr_data) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (wr_sel[i]) begin
                        key_reg[i]  <= in_key;
                        data_reg[i] <= in_value;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/lru_key_value_cache_tb.sv =====
// Self-checking testbench for the LRU key-value cache: directed table, then random phases.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

    import lru_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] rv;
        logic              ev;
    } lookup_result_t;

    typedef struct packed {
        func_t             op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] val;
        logic              pinned;
        lookup_result_t    want;
    } probe_row_t;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 238;
    localparam int POOL_SIZE    = 20;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 60;
    localparam int N_PROBES     = 18;

    localparam lookup_result_t SET_NEW = '0;
    localparam lookup_result_t MISS_R  = '{1'b0, MISS_VALUE, 1'b0};
    localparam lookup_result_t SET_HIT = '{1'b1, 32'h0000_0000, 1'b0};

    // pinned rows carry the answer that follows directly from the op; the rest go to the predictor
    localparam probe_row_t PROBES [N_PROBES] = '{
        '{FUNC_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS_R},
        '{FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, MISS_R},
        '{FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, SET_NEW},
        '{FUNC_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0}},
        '{FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, SET_NEW},
        '{FUNC_GET, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
        '{FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, SET_NEW},
        // stored -1 must come back as a hit
        '{FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, MISS_VALUE, 1'b0}},
        '{FUNC_SET, 32'h0000_0000, 32'h0000_0000, 1'b1, SET_NEW},
        '{FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
        '{FUNC_SET, 32'h8000_0000, 32'h0000_0005, 1'b1, SET_HIT},
        '{FUNC_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0005, 1'b0}},
        '{FUNC_SET, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, SET_HIT},
        '{FUNC_GET, 32'h1234_5678, 32'hDEAD_BEEF, 1'b1, MISS_R},
        '{FUNC_SET, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, SET_NEW},
        '{FUNC_SET, 32'h0000_0002, 32'h5A5A_5A5A, 1'b0, SET_NEW},
        '{FUNC_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, SET_NEW},
        '{FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, SET_NEW}
    };

    // capacity per phase; phase 0 runs on the reset value
    localparam logic [CAP_W-1:0] PHASE_CAP [PHASES] = '{
        5'd16, 5'd31, 5'd1, 5'd0, 5'd6, 5'd17, 5'd2, 5'd16
    };

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;     // key[31:0], value[63:32]
    logic              s_tuser;     // func
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;     // read_value[31:0]
    logic [1:0]        m_tuser;     // hit[0], evicted[1]

    // travels with each request beat so the monitor knows about pinned rows
    logic              beat_pinned;
    lookup_result_t    beat_pin;

    int                snd_idle;
    int                rcv_idle;
    bit                stall_req;
    int                mismatches;
    int                quiet;

    // shadow cache state
    bit                slot_valid [ENTRIES];
    logic [KEY_W-1:0]  slot_key   [ENTRIES];
    logic [DATA_W-1:0] slot_data  [ENTRIES];
    int unsigned       slot_age   [ENTRIES];
    int unsigned       fill;
    logic [CAP_W-1:0]  cap_reg;
    lookup_result_t    pending_replies [$];

    always #1 aclk = ~aclk;

    lru_key_value_cache dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // make slot most recent, aging everything that was newer
    function automatic void promote(int slot);
        int unsigned a;
        a = slot_age[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] < a) slot_age[i]++;
        slot_age[slot] = 0;
    endfunction

    function automatic lookup_result_t lru_access(func_t op, logic [KEY_W-1:0] k,
                                                  logic [DATA_W-1:0] v);
        lookup_result_t r;
        int             hit_slot;
        int             victim;
        int             free_slot;
        int unsigned    limit;
        hit_slot  = -1;
        victim    = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == k) hit_slot = i;
        r     = '0;
        r.hit = (hit_slot >= 0);
        if (op == FUNC_GET) begin
            if (hit_slot >= 0) begin
                r.rv = slot_data[hit_slot];
                promote(hit_slot);
            end else begin
                r.rv = MISS_VALUE;
            end
        end else if (hit_slot >= 0) begin
            slot_data[hit_slot] = v;
            promote(hit_slot);
        end else begin
            limit = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
            // occupancy above a lowered capacity stays put: one out, one in
            if (fill >= limit) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                        victim = i;
                slot_valid[victim] = 1'b0;
                fill--;
                r.ev = 1'b1;
            end
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (!slot_valid[i]) free_slot = i;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i]) slot_age[i]++;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = k;
            slot_data[free_slot]  = v;
            slot_age[free_slot]   = 0;
            fill++;
        end
        return r;
    endfunction

    // monitor: check result beats against the oldest expectation, predict on request beats
    always @(posedge aclk) begin
        lookup_result_t got;
        lookup_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_data[i]  = '0;
                slot_age[i]   = 0;
            end
            fill    = 0;
            cap_reg = CAP_RESET;
            pending_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser[0], m_tdata, m_tuser[1]};
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: hit=%0b value=%h evicted=%0b",
                                 got.hit, got.rv, got.ev);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.hit !== want.hit || got.rv !== want.rv || got.ev !== want.ev) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: hit %0b/%0b value %h/%h evicted %0b/%0b (exp/got)",
                                     want.hit, got.hit, want.rv, got.rv, want.ev, got.ev);
                    end
                end
            end
            if (cfg_valid && cfg_ready) cap_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                got = lru_access(func_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
                pending_replies.push_back(beat_pinned ? beat_pin : got);
            end
        end
    end

    // receiver: random backpressure, plus a long hold when requested
    initial begin : receiver
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic offer(func_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v,
                         logic pinned, lookup_result_t want);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tuser     <= op;
        s_tdata     <= {v, k};
        beat_pinned <= pinned;
        beat_pin    <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off the sender until every expected result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0]  key_pool [POOL_SIZE];
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] v;
        func_t             op;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        beat_pinned = 1'b0;
        beat_pin    = '0;
        snd_idle    = 14;
        rcv_idle    = 56;
        stall_req   = 1'b0;
        mismatches  = 0;
        quiet       = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < N_PROBES; n++)
            offer(PROBES[n].op, PROBES[n].key, PROBES[n].val, PROBES[n].pinned,
                  PROBES[n].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph > 0) begin
                cfg_valid <= 1'b1;
                cfg_data  <= PHASE_CAP[ph];
                do @(posedge aclk); while (!cfg_ready);
                cfg_valid <= 1'b0;
            end
            if (ph < 3) begin
                snd_idle = 14;
                rcv_idle = 56;
            end else if (ph < 6) begin
                snd_idle = 56;
                rcv_idle = 14;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            // small key pool so hits, updates and evictions all happen often
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'h8000_0000;
            key_pool[2] = 32'h7FFF_FFFF;
            key_pool[3] = 32'hFFFF_FFFF;
            for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((ph == 1 && n == 100) || (ph == 4 && n == 50) || (ph == 7 && n == 20))
                    stall_req = 1'b1;
                op = $urandom_range(0, 1) ? FUNC_SET : FUNC_GET;
                k  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                  : $urandom;
                case ($urandom_range(0, 15))
                    0:       v = 32'hFFFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h7FFF_FFFF;
                    default: v = $urandom;
                endcase
                offer(op, k, v, 1'b0, SET_NEW);
            end
        end

        settle();
        repeat (3) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== lru_key_value_cache.f =====
design/lru_pkg.sv
design/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
